### hdl/bounded_deque_with_search_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque with search
// Concurrent assertion shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define BDQS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("bdqs assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define BDQS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdqs assertion failed");

// The consequent holds in the cycle after the antecedent.
`define BDQS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdqs assertion failed");

`endif

### hdl/bdqs_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque with search package
// Operation and status codes and the transaction payload types.
// ----------------------------------------------------------------------------
package bdqs_pkg;

  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  localparam logic [OP_W-1:0] OP_PUSH_HEAD    = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_TAIL    = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_HEAD     = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_TAIL     = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_AT    = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 3'd5;
  localparam logic [OP_W-1:0] OP_CONTAINS     = 3'd6;
  localparam logic [OP_W-1:0] OP_READ_AT      = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;
  } bdqs_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic                    found;
    logic [STAT_W-1:0]       status;
    logic [OCC_W-1:0]        occupancy;
  } bdqs_out_t;

endpackage

### hdl/bdqs_mem.sv
// ----------------------------------------------------------------------------
// Bounded deque entry memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bdqs_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [bdqs_pkg::VAL_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [bdqs_pkg::VAL_W-1:0] rdata
);
  import bdqs_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/bdqs_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded deque sequencer
// Decodes one transaction, walks the ring for searches and closes gaps by
// copying entries down one slot per cycle through the entry memory.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_search_unit_assert.svh"

module bdqs_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bdqs_pkg::bdqs_in_t         in_data,
  input  logic                       out_free,
  output logic                       done,
  output bdqs_pkg::bdqs_out_t        res,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [bdqs_pkg::VAL_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  logic [bdqs_pkg::VAL_W-1:0] mem_rdata
);
  import bdqs_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int SW   = CW + 1;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     rd_i_r, rd_i_nxt;
  logic [CW-1:0]     wr_i_r, wr_i_nxt;
  logic [CW-1:0]     cmp_i_r, cmp_i_nxt;
  logic              dvalid_r, dvalid_nxt;
  logic              first_r, first_nxt;
  logic [VAL_W-1:0]  res_val_r, res_val_nxt;
  logic              found_r, found_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  logic              full;
  logic              empty;
  logic              pos_oob;
  logic [CW-1:0]     pos_idx;
  logic [CW-1:0]     last_i;
  logic [AW-1:0]     head_dec;
  logic [AW-1:0]     head_inc;
  logic              is_push;
  logic              push_ok;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] x);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(x);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign pos_oob  = (CMPW'(pos_r) >= CMPW'(count_r));
  assign pos_idx  = CW'(pos_r);
  assign last_i   = count_r - 1'b1;
  assign head_dec = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - 1'b1;
  assign head_inc = (head_r == AW'(CAPACITY - 1)) ? '0 : head_r + 1'b1;
  assign is_push  = (op_r == OP_PUSH_HEAD) || (op_r == OP_PUSH_TAIL);
  assign push_ok  = (state_r == S_DISP) && is_push && !full;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    pos_nxt     = pos_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    rd_i_nxt    = rd_i_r;
    wr_i_nxt    = wr_i_r;
    cmp_i_nxt   = cmp_i_r;
    dvalid_nxt  = dvalid_r;
    first_nxt   = first_r;
    res_val_nxt = res_val_r;
    found_nxt   = found_r;
    status_nxt  = status_r;
    mem_we      = 1'b0;
    mem_waddr   = slot_of(head_r, wr_i_r);
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = slot_of(head_r, rd_i_r);
    done        = 1'b0;
    in_stall    = (state_r != S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_data.operation;
          val_nxt     = in_data.item_value;
          pos_nxt     = in_data.position;
          res_val_nxt = '0;
          found_nxt   = 1'b0;
          status_nxt  = ST_OK;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        case (op_r) inside
          OP_PUSH_HEAD, OP_PUSH_TAIL: begin
            state_nxt = S_DONE;
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = val_r;
              count_nxt = count_r + 1'b1;
              if (op_r == OP_PUSH_HEAD) begin
                head_nxt  = head_dec;
                mem_waddr = head_dec;
              end else begin
                mem_waddr = slot_of(head_r, count_r);
              end
            end
          end
          OP_POP_HEAD, OP_POP_TAIL: begin
            if (empty) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              mem_re    = 1'b1;
              count_nxt = count_r - 1'b1;
              state_nxt = S_RDWAIT;
              if (op_r == OP_POP_HEAD) begin
                mem_raddr = head_r;
                head_nxt  = head_inc;
              end else begin
                mem_raddr = slot_of(head_r, last_i);
              end
            end
          end
          OP_REMOVE_AT, OP_READ_AT: begin
            if (empty) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else if (pos_oob) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = slot_of(head_r, pos_idx);
              if (op_r == OP_READ_AT) begin
                state_nxt = S_RDWAIT;
              end else begin
                wr_i_nxt   = pos_idx;
                rd_i_nxt   = pos_idx + 1'b1;
                dvalid_nxt = 1'b1;
                first_nxt  = 1'b1;
                state_nxt  = S_SHIFT;
              end
            end
          end
          default: begin
            if (op_r == OP_REMOVE_VALUE && empty) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              rd_i_nxt   = '0;
              dvalid_nxt = 1'b0;
              state_nxt  = S_SEARCH;
            end
          end
        endcase
      end
      S_RDWAIT: begin
        res_val_nxt = mem_rdata;
        state_nxt   = S_DONE;
      end
      S_SEARCH: begin
        if (dvalid_r && mem_rdata == val_r) begin
          found_nxt  = 1'b1;
          dvalid_nxt = 1'b0;
          if (op_r == OP_REMOVE_VALUE) begin
            res_val_nxt = mem_rdata;
            wr_i_nxt    = cmp_i_r;
            rd_i_nxt    = cmp_i_r + 1'b1;
            first_nxt   = 1'b0;
            state_nxt   = S_SHIFT;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (rd_i_r < count_r) begin
          mem_re     = 1'b1;
          cmp_i_nxt  = rd_i_r;
          rd_i_nxt   = rd_i_r + 1'b1;
          dvalid_nxt = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (dvalid_r) begin
          if (first_r) begin
            res_val_nxt = mem_rdata;
          end else begin
            mem_we   = 1'b1;
            wr_i_nxt = wr_i_r + 1'b1;
          end
        end
        first_nxt = 1'b0;
        if (rd_i_r < count_r) begin
          mem_re     = 1'b1;
          rd_i_nxt   = rd_i_r + 1'b1;
          dvalid_nxt = 1'b1;
        end else begin
          dvalid_nxt = 1'b0;
          count_nxt  = count_r - 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      dvalid_r <= 1'b0;
      first_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      dvalid_r <= dvalid_nxt;
      first_r  <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    pos_r     <= pos_nxt;
    rd_i_r    <= rd_i_nxt;
    wr_i_r    <= wr_i_nxt;
    cmp_i_r   <= cmp_i_nxt;
    res_val_r <= res_val_nxt;
    found_r   <= found_nxt;
    status_r  <= status_nxt;
  end

  assign res.result_value = res_val_r;
  assign res.found        = found_r;
  assign res.status       = status_r;
  assign res.occupancy    = OCC_W'(count_r);

  `BDQS_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(CAPACITY))
  `BDQS_ASSERT_IMPL(a_no_rw_collide, mem_we && mem_re, mem_waddr != mem_raddr)
  `BDQS_ASSERT_IMPL(a_full_only_push, state_r == S_DISP && status_nxt == ST_FULL, is_push)
  `BDQS_ASSERT_NEXT(a_push_grows, push_ok, count_r == CW'($past(count_r) + 1'b1))

endmodule

### hdl/bounded_deque_with_search_unit.sv
// A push runs through the dispatch and done states into the result register; a pop or read
// also passes a read wait state. Contains and remove value search with one entry read a cycle,
// and remove value and remove at then copy the later entries down one slot in the shift state.
// One transaction at a time: a new one is taken only once the last has left the done state.
// Reset clears head and count; the entry memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Bounded deque with search unit
// Top level: sequencer, entry memory and the result output register.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bdqs_pkg::bdqs_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bdqs_pkg::bdqs_out_t out_data
);
  import bdqs_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic             out_valid_r, out_valid_nxt;
  bdqs_out_t        out_data_r, out_data_nxt;
  logic             out_free;
  logic             done;
  bdqs_out_t        res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  bdqs_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_free  (out_free),
    .done      (done),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bdqs_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (done) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
